// ----- rtl/mfpd_pkg.sv -----
`default_nettype none

package mfpd_pkg;

    // Widths of the fixed fields
    localparam int ADC_WIDTH_DEF = 12;
    localparam int POS_W         = 7;
    localparam int CAL_W         = 11;
    localparam int DZ_W          = 7;
    localparam int TGT_IN_W      = 8;
    localparam int SPEED_W       = 8;
    localparam int ON_W          = 13;
    localparam int OFF_W         = 12;
    localparam int DIR_W         = 2;
    localparam int CFG_IDX_W     = 2;

    // Scaling divider: dividend is (reading - min_adc) * 127, quotient stays below 128
    localparam int NUM_W     = CAL_W + POS_W;
    localparam int DIV_STEPS = POS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Reset values of the registers and state
    localparam logic [CAL_W-1:0] MIN_ADC_RST = 11'd10;
    localparam logic [CAL_W-1:0] MAX_ADC_RST = 11'd1024;
    localparam logic [DZ_W-1:0]  DZ_RST      = 7'd2;

    localparam logic [TGT_IN_W-1:0] TGT_MAX     = 8'd127;
    localparam logic [POS_W-1:0]    FAR_DIST    = 7'd50;
    localparam logic [SPEED_W-1:0]  SPEED_BASE  = 8'd60;
    localparam logic [SPEED_W-1:0]  SPEED_MAX   = 8'd255;
    localparam logic [SPEED_W-1:0]  ENABLE_MIN  = 8'd5;
    localparam logic [ON_W-1:0]     ON_BASE     = 13'd200;
    localparam logic [OFF_W-1:0]    OFF_BASE    = 12'd4000;

    // Reciprocal constants: dist*195/50 and speed*5800/255, speed*3950/255
    localparam int                SPD_K_W  = 22;
    localparam logic [SPD_K_W-1:0] SPD_K   = 22'd4089540;
    localparam int                SPD_SH   = 20;
    localparam int                ON_K_W   = 34;
    localparam logic [ON_K_W-1:0] ON_K     = 34'd12211186600;
    localparam int                OFF_K_W  = 33;
    localparam logic [OFF_K_W-1:0] OFF_K   = 33'd8316239150;
    localparam int                PWM_SH   = 29;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ADC,
        REG_MAX_ADC,
        REG_DEAD_ZONE
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DRIVE,
        ST_SPEED,
        ST_PWM_ON,
        ST_PWM_OFF
    } mfpd_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [CAL_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [POS_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/mfpd_div.sv -----
`default_nettype none

module mfpd_div
    import mfpd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int SH_W = CAL_W + DIV_STEPS - 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [SH_W-1:0]  dsh_reg, dsh_next;
    logic [POS_W-1:0] quo_reg, quo_next;

    logic [NUM_W-1:0] trial;
    logic             fits;

    assign trial = NUM_W'(dsh_reg);
    assign fits  = rem_reg >= trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS - 1);
            rem_next  = req.num;
            dsh_next  = {req.den, {(DIV_STEPS-1){1'b0}}};
            quo_next  = '0;
        end else if (busy_reg) begin
            // one restoring step: try the shifted divisor, keep the bit
            if (fits) begin
                rem_next = rem_reg - trial;
            end
            quo_next = {quo_reg[POS_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/motor_fader_position_drive.sv -----
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tuser: req_type; tdata: target, sample
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: position .. pwm_off_us
// cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// A set-target transaction updates the target and clears the reached flag, with no
// output. A sample transaction runs prepare, 7 restoring steps of the divider plus
// its done strobe, then drive decision, speed and the two PWM reciprocal multiplies.
// A stop skips the speed state; an empty calibration span skips the divider.
// aresetn is synchronous, active low; it resets control state, target and position,
// sets the reached flag and loads the calibration register defaults.
// A full output register stalls the last stage; the input side is busy meanwhile.
`default_nettype none

module motor_fader_position_drive
    import mfpd_pkg::*;
#(
    parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] target_pos, [ADC_WIDTH+7:8] adc_sample, zero pad above
    input  wire logic [((TGT_IN_W+ADC_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // [0] req_type
    input  wire logic                 s_axis_tuser,

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [6:0] position, [13:7] target_now, [15:14] direction, [23:16] motor_speed,
    // [24] motor_enable, [37:25] pwm_on_us, [49:38] pwm_off_us, zero pad above
    output logic [55:0]               m_axis_tdata,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CAL_W-1:0]     cfg_data
);

    localparam int SW      = ((ADC_WIDTH > CAL_W) ? ADC_WIDTH : CAL_W) + 1;
    localparam int OUT_W   = POS_W + POS_W + DIR_W + SPEED_W + 1 + ON_W + OFF_W;
    localparam int SPD_P_W = POS_W + SPD_K_W;
    localparam int ON_P_W  = SPEED_W + ON_K_W;
    localparam int OFF_P_W = SPEED_W + OFF_K_W;

    mfpd_state_t state_reg, state_next;

    logic [CAL_W-1:0]           min_adc_reg, max_adc_reg;
    logic [DZ_W-1:0]            dz_reg;
    logic [POS_W-1:0]           target_reg, target_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       reached_reg, reached_next;
    logic signed [ADC_WIDTH-1:0] sample_reg, sample_next;
    logic [POS_W-1:0]           dist_reg, dist_next;
    dir_t                       dir_reg, dir_next;
    logic [SPEED_W-1:0]         speed_reg, speed_next;
    logic [ON_W-1:0]            on_reg, on_next;
    logic                       m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]           m_data_reg, m_data_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                       s_fire, out_free;
    logic [TGT_IN_W-1:0]        tgt_in;
    logic signed [SW-1:0]       samp_s, lo_s, hi_s, clip_s, diff_s;
    logic [CAL_W-1:0]           diff_u;
    logic                       span_empty;
    logic [POS_W-1:0]           dist_w;
    logic [SPD_P_W-1:0]         spd_prod;
    logic [ON_P_W-1:0]          on_prod;
    logic [OFF_P_W-1:0]         off_prod;
    logic [OFF_W-1:0]           off_w;

    mfpd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign tgt_in        = s_axis_tdata[TGT_IN_W-1:0];

    // clamp the reading into the calibration span
    assign samp_s     = SW'(sample_reg);
    assign lo_s       = signed'({{(SW-CAL_W){1'b0}}, min_adc_reg});
    assign hi_s       = signed'({{(SW-CAL_W){1'b0}}, max_adc_reg});
    assign clip_s     = (samp_s < lo_s) ? lo_s : ((samp_s > hi_s) ? hi_s : samp_s);
    assign diff_s     = clip_s - lo_s;
    assign diff_u     = diff_s[CAL_W-1:0];
    assign span_empty = (max_adc_reg <= min_adc_reg);

    assign dist_w = (pos_reg > target_reg) ? (pos_reg - target_reg) : (target_reg - pos_reg);

    assign spd_prod = {{SPD_K_W{1'b0}}, dist_reg} * {{POS_W{1'b0}}, SPD_K};
    assign on_prod  = {{ON_K_W{1'b0}}, speed_reg} * {{SPEED_W{1'b0}}, ON_K};
    assign off_prod = {{OFF_K_W{1'b0}}, speed_reg} * {{SPEED_W{1'b0}}, OFF_K};
    assign off_w    = OFF_BASE - off_prod[PWM_SH+OFF_W-1:PWM_SH];

    always_comb begin
        state_next   = state_reg;
        target_next  = target_reg;
        pos_next     = pos_reg;
        reached_next = reached_reg;
        sample_next  = sample_reg;
        dist_next    = dist_reg;
        dir_next     = dir_reg;
        speed_next   = speed_reg;
        on_next      = on_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_req.start = 1'b0;
        div_req.num   = ({diff_u, {POS_W{1'b0}}}) - NUM_W'(diff_u);
        div_req.den   = max_adc_reg - min_adc_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (!s_axis_tuser) begin
                        target_next  = (tgt_in > TGT_MAX) ? TGT_MAX[POS_W-1:0]
                                                          : tgt_in[POS_W-1:0];
                        reached_next = 1'b0;
                    end else begin
                        sample_next = s_axis_tdata[TGT_IN_W+ADC_WIDTH-1:TGT_IN_W];
                        state_next  = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                if (span_empty) begin
                    pos_next   = '0;
                    state_next = ST_DRIVE;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    pos_next   = div_rsp.quo;
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE: begin
                dist_next = dist_w;
                if ((dist_w > dz_reg) && !reached_reg) begin
                    dir_next   = (pos_reg < target_reg) ? DIR_UP : DIR_DOWN;
                    state_next = ST_SPEED;
                end else begin
                    reached_next = 1'b1;
                    dir_next     = DIR_STOP;
                    speed_next   = '0;
                    state_next   = ST_PWM_ON;
                end
            end
            ST_SPEED: begin
                if (dist_reg >= FAR_DIST) begin
                    speed_next = SPEED_MAX;
                end else begin
                    speed_next = spd_prod[SPD_SH+SPEED_W-1:SPD_SH] + SPEED_BASE;
                end
                state_next = ST_PWM_ON;
            end
            ST_PWM_ON: begin
                on_next    = ON_BASE + on_prod[PWM_SH+ON_W-1:PWM_SH];
                state_next = ST_PWM_OFF;
            end
            ST_PWM_OFF: begin
                // hold here until the output register can take the result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {off_w, on_reg, speed_reg > ENABLE_MIN, speed_reg,
                                    dir_reg, target_reg, pos_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            target_reg  <= '0;
            pos_reg     <= '0;
            reached_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            target_reg  <= target_next;
            pos_reg     <= pos_next;
            reached_reg <= reached_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg <= sample_next;
        dist_reg   <= dist_next;
        dir_reg    <= dir_next;
        speed_reg  <= speed_next;
        on_reg     <= on_next;
        m_data_reg <= m_data_next;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_adc_reg <= MIN_ADC_RST;
            max_adc_reg <= MAX_ADC_RST;
            dz_reg      <= DZ_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_ADC:   min_adc_reg <= cfg_data;
                REG_MAX_ADC:   max_adc_reg <= cfg_data;
                REG_DEAD_ZONE: dz_reg      <= cfg_data[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(56-OUT_W){1'b0}}, m_data_reg};

`ifndef SYNTHESIS
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("input accepted while a sample is in work");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider result outside the divide phase");

    a_div_busy_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide phase");

    a_stop_no_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[15:14] == DIR_STOP))
        |-> (m_axis_tdata[23:16] == '0) && !m_axis_tdata[24])
        else $error("stopped motor with nonzero speed");

    a_move_min_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[15:14] != DIR_STOP))
        |-> (m_axis_tdata[23:16] >= SPEED_BASE) && m_axis_tdata[24])
        else $error("moving motor below minimum speed");

    a_reached_after_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_axis_tvalid) && (m_axis_tdata[15:14] == DIR_STOP)) |-> reached_reg)
        else $error("stop result without reached flag");
`endif

endmodule

`default_nettype wire

// ----- verif/motor_fader_position_drive_tb.sv -----
`timescale 1ns / 100ps

module motor_fader_position_drive_tb;
    import mfpd_pkg::*;

    localparam logic REQ_TARGET = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;
    // index past the register list; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [6:0]  position;
        logic [6:0]  target_now;
        dir_t        direction;
        logic [7:0]  speed;
        logic        enable;
        logic [12:0] pwm_on;
        logic [11:0] pwm_off;
    } motor_cmd_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [7:0] target_pos, [19:8] adc_sample, [23:20] zero
    logic [23:0]          s_axis_tdata = '0;
    // [0] req_type
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [6:0] position, [13:7] target_now, [15:14] direction, [23:16] motor_speed,
    // [24] motor_enable, [37:25] pwm_on_us, [49:38] pwm_off_us, [55:50] zero
    logic [55:0]          m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAL_W-1:0]     cfg_data = '0;

    // predictor copy of the registers and state
    int         cal_min = 10;
    int         cal_max = 1024;
    int         cal_dead_zone = 2;
    logic [6:0] tgt_pos = '0;
    logic [6:0] cur_pos = '0;
    logic       at_target = 1'b1;

    motor_cmd_t motor_commands[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         tx_idle_pct = 34;
    int         rx_idle_pct = 34;
    int         rx_hold_cycles = 0;

    motor_fader_position_drive dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void drive_fader(input logic req, input logic [7:0] tgt_in,
                                        input logic [11:0] adc_in);
        motor_cmd_t cmd;
        int r, p, t, gap, spd;
        if (req == REQ_TARGET) begin
            tgt_pos = (tgt_in > 8'd127) ? 7'd127 : tgt_in[6:0];
            at_target = 1'b0;
            return;
        end
        r = $signed(adc_in);
        if (cal_max <= cal_min) begin
            cur_pos = '0;
        end else begin
            if (r < cal_min) r = cal_min;
            if (r > cal_max) r = cal_max;
            cur_pos = 7'((r - cal_min) * 127 / (cal_max - cal_min));
        end
        p = cur_pos;
        t = tgt_pos;
        gap = (p > t) ? p - t : t - p;
        spd = 0;
        cmd.direction = DIR_STOP;
        if (gap > cal_dead_zone && !at_target) begin
            cmd.direction = (p < t) ? DIR_UP : DIR_DOWN;
            spd = gap * 195 / 50 + 60;
            if (spd > 255) spd = 255;
        end else begin
            at_target = 1'b1;
        end
        cmd.position   = cur_pos;
        cmd.target_now = tgt_pos;
        cmd.speed      = spd[7:0];
        cmd.enable     = (spd > 5);
        cmd.pwm_on     = 13'(200 + spd * 5800 / 255);
        cmd.pwm_off    = 12'(4000 - spd * 3950 / 255);
        motor_commands.push_back(cmd);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        motor_cmd_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (motor_commands.size() == 0) begin
                $error("result transaction with no command pending: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = motor_commands.pop_front();
                check_field("position",     want.position,   m_axis_tdata[6:0]);
                check_field("target_now",   want.target_now, m_axis_tdata[13:7]);
                check_field("direction",    want.direction,  m_axis_tdata[15:14]);
                check_field("motor_speed",  want.speed,      m_axis_tdata[23:16]);
                check_field("motor_enable", want.enable,     m_axis_tdata[24]);
                check_field("pwm_on_us",    want.pwm_on,     m_axis_tdata[37:25]);
                check_field("pwm_off_us",   want.pwm_off,    m_axis_tdata[49:38]);
                check_field("pad",          0,               m_axis_tdata[55:50]);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end
            m_axis_tready = (int'($urandom_range(0, 99)) >= rx_idle_pct);
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic req, input int tgt, input int adc);
        while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {4'b0, adc[11:0], tgt[7:0]};
        do @(posedge aclk); while (!s_axis_tready);
        drive_fader(req, tgt[7:0], adc[11:0]);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CAL_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MIN_ADC:   cal_min = value[CAL_W-1:0];
            REG_MAX_ADC:   cal_max = value[CAL_W-1:0];
            REG_DEAD_ZONE: cal_dead_zone = value[DZ_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // a set-target may still be in flight after the last result
    task automatic wait_for_drain();
        while (motor_commands.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_reset_defaults();
        // reached flag is set out of reset, so every sample reports a stopped motor
        send_item(REQ_SAMPLE, 8'hFF, -2048);
        send_item(REQ_SAMPLE, 8'h00, 0);
        send_item(REQ_SAMPLE, 8'hAA, 10);
        send_item(REQ_SAMPLE, 8'h55, 1024);
        send_item(REQ_SAMPLE, 8'h80, 2047);
    endtask

    task automatic test_drive_directions();
        send_item(REQ_TARGET, 255, -1);
        send_item(REQ_SAMPLE, 0, 10);
        send_item(REQ_SAMPLE, 0, 944);
        send_item(REQ_SAMPLE, 0, 1024);
        send_item(REQ_SAMPLE, 0, 10);
        send_item(REQ_TARGET, 0, 0);
        send_item(REQ_SAMPLE, 0, 2047);
        send_item(REQ_SAMPLE, 0, 40);
        send_item(REQ_SAMPLE, 0, 30);
    endtask

    task automatic test_calibration_edges();
        wait_for_drain();
        write_reg(REG_DEAD_ZONE, 0);
        send_item(REQ_TARGET, 64, 0);
        send_item(REQ_SAMPLE, 0, 514);
        wait_for_drain();
        write_reg(REG_UNUSED, $urandom_range(0, 2047));
        write_reg(REG_MIN_ADC, 500);
        write_reg(REG_MAX_ADC, 500);
        send_item(REQ_SAMPLE, 0, 700);
        wait_for_drain();
        write_reg(REG_MIN_ADC, 600);
        write_reg(REG_MAX_ADC, 400);
        send_item(REQ_SAMPLE, 0, -5);
        wait_for_drain();
        write_reg(REG_MIN_ADC, 0);
        write_reg(REG_MAX_ADC, 2047);
        write_reg(REG_DEAD_ZONE, 11'h7FF);
        send_item(REQ_SAMPLE, 0, 2047);
        send_item(REQ_SAMPLE, 0, -1);
    endtask

    // mostly a target followed by samples of a wiper closing in on it
    task automatic run_traffic(input int n_items);
        int sent, wiper, goal, t, tc, steps, roll;
        sent  = 0;
        wiper = int'($urandom_range(0, 4095)) - 2048;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                send_item(REQ_SAMPLE, $urandom_range(0, 255), int'($urandom_range(0, 4095)) - 2048);
                sent++;
            end else if (roll < 12) begin
                send_item(REQ_TARGET, $urandom_range(0, 255), int'($urandom_range(0, 4095)) - 2048);
                sent++;
            end else begin
                t = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 127);
                send_item(REQ_TARGET, t, int'($urandom_range(0, 4095)) - 2048);
                sent++;
                tc = (t > 127) ? 127 : t;
                if (cal_max > cal_min)
                    goal = cal_min + tc * (cal_max - cal_min) / 127;
                else
                    goal = cal_min + int'($urandom_range(0, 200)) - 100;
                steps = $urandom_range(2, 12);
                repeat (steps) begin
                    wiper = wiper + (goal - wiper) / 3 + int'($urandom_range(0, 40)) - 20;
                    if (wiper < -2048) wiper = -2048;
                    if (wiper > 2047) wiper = 2047;
                    send_item(REQ_SAMPLE, $urandom_range(0, 255), wiper);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        int lo, hi, dz, n;
        for (int phase = 0; phase < 7; phase++) begin
            wait_for_drain();
            n = 300;
            tx_idle_pct = 34;
            rx_idle_pct = 34;
            case (phase)
                0: begin lo = 10; hi = 1024; dz = 2; end
                1: begin
                    lo = 0; hi = 2047; dz = 0;
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                2: begin lo = 0; hi = 2047; dz = 127; end
                3: begin
                    lo = $urandom_range(0, 1500);
                    hi = $urandom_range(lo + 1, 2047);
                    dz = $urandom_range(0, 20);
                end
                4: begin lo = $urandom_range(0, 2046); hi = lo + 1; dz = 0; end
                5: begin
                    lo = $urandom_range(1, 2047);
                    hi = $urandom_range(0, lo);
                    dz = $urandom_range(0, 127);
                    n  = 100;
                end
                default: begin
                    lo = $urandom_range(0, 2047);
                    hi = $urandom_range(0, 2047);
                    dz = $urandom_range(0, 2047);
                end
            endcase
            write_reg(REG_MIN_ADC, lo);
            write_reg(REG_MAX_ADC, hi);
            write_reg(REG_DEAD_ZONE, dz);
            run_traffic(n);
        end
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        write_reg(REG_MIN_ADC, 10);
        write_reg(REG_MAX_ADC, 1024);
        write_reg(REG_DEAD_ZONE, 2);
        tx_idle_pct = 0;
        rx_hold_cycles = 400;
        send_item(REQ_TARGET, 100, 0);
        for (int i = 0; i < 30; i++)
            send_item(REQ_SAMPLE, $urandom_range(0, 255), int'($urandom_range(0, 1100)));
        tx_idle_pct = 34;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_drive_directions();
        test_calibration_edges();
        test_random_traffic();
        test_backpressure();
        wait_for_drain();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
